[rtl/hrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and constants for the heating relay controller.
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int TIMER_BITS = 22;
    localparam int SP_W       = 10;
    localparam int BAND_W     = 8;
    localparam int TICK_W     = 22;
    localparam int TEMP_W     = 12;
    localparam int CMP_W      = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
    localparam int ERR_W      = TEMP_W + 2;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [SP_W-1:0]   SETPOINT_MAX   = SP_W'(512);
    localparam logic [SP_W-1:0]   SETPOINT_RESET = SP_W'(336);
    localparam logic [BAND_W-1:0] BAND_RESET     = BAND_W'(16);
    localparam logic [TICK_W-1:0] MAX_ON_RESET   = TICK_W'(1800000);
    localparam logic [TICK_W-1:0] MIN_OFF_RESET  = TICK_W'(300000);

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_ON       = 2'd1,
        EV_OFF_TIME = 2'd2,
        EV_OFF_TEMP = 2'd3
    } event_t;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_SETPOINT = 2'd0,
        REG_BAND     = 2'd1,
        REG_MAX_ON   = 2'd2,
        REG_MIN_OFF  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SP_W-1:0]   setpoint;
        logic [BAND_W-1:0] hysteresis_band;
        logic [TICK_W-1:0] max_on_ticks;
        logic [TICK_W-1:0] min_off_ticks;
    } cfg_t;

endpackage

[rtl/hrc_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_cfg
// APB register file: setpoint, hysteresis band, max on time, min off time.
// ----------------------------------------------------------------------------
module hrc_cfg
    import hrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint        <= SETPOINT_RESET;
            cfg_reg.hysteresis_band <= BAND_RESET;
            cfg_reg.max_on_ticks    <= MAX_ON_RESET;
            cfg_reg.min_off_ticks   <= MIN_OFF_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SETPOINT:
                begin
                    // out-of-range setpoint is dropped
                    if (pwdata[SP_W-1:0] <= SETPOINT_MAX)
                        cfg_reg.setpoint <= pwdata[SP_W-1:0];
                end
                REG_BAND:    cfg_reg.hysteresis_band <= pwdata[BAND_W-1:0];
                REG_MAX_ON:  cfg_reg.max_on_ticks    <= pwdata[TICK_W-1:0];
                REG_MIN_OFF: cfg_reg.min_off_ticks   <= pwdata[TICK_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SETPOINT: prdata = APB_DW'(cfg_reg.setpoint);
            REG_BAND:     prdata = APB_DW'(cfg_reg.hysteresis_band);
            REG_MAX_ON:   prdata = APB_DW'(cfg_reg.max_on_ticks);
            REG_MIN_OFF:  prdata = APB_DW'(cfg_reg.min_off_ticks);
            default:      prdata = '0;
        endcase
    end

endmodule

[rtl/hrc_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_core
// Relay state, first-run flag, saturating timers and the turn on/off decision.
// ----------------------------------------------------------------------------
module hrc_core
    import hrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              fire,
    input  op_t               op,
    input  logic [TEMP_W-1:0] temperature,
    output logic              heater_on,
    output event_t            event_res
);

    logic                  relay_reg, relay_next;
    logic                  first_run_reg, first_run_next;
    logic [TIMER_BITS-1:0] on_elapsed_reg, on_elapsed_next;
    logic [TIMER_BITS-1:0] off_elapsed_reg, off_elapsed_next;

    logic signed [ERR_W-1:0] temp_s;
    logic signed [ERR_W-1:0] sp_s;
    logic signed [ERR_W-1:0] diff;
    logic signed [ERR_W-1:0] err2;
    logic signed [ERR_W-1:0] band_s;
    logic                    max_hit;
    logic                    waited;
    logic                    temp_below;
    event_t                  ev;

    assign temp_s     = ERR_W'($signed(temperature));
    assign sp_s       = $signed(ERR_W'(cfg.setpoint));
    assign band_s     = $signed(ERR_W'(cfg.hysteresis_band));
    assign diff       = sp_s - temp_s;
    assign err2       = diff <<< 1;
    assign temp_below = (temp_s < sp_s);
    assign max_hit    = (CMP_W'(on_elapsed_reg) >= CMP_W'(cfg.max_on_ticks));
    assign waited     = (CMP_W'(off_elapsed_reg) >= CMP_W'(cfg.min_off_ticks))
                        || first_run_reg;

    always_comb
    begin
        relay_next       = relay_reg;
        first_run_next   = first_run_reg;
        on_elapsed_next  = on_elapsed_reg;
        off_elapsed_next = off_elapsed_reg;
        ev               = EV_NONE;
        case (op)
            OP_TICK:
            begin
                if (on_elapsed_reg != '1)
                    on_elapsed_next = on_elapsed_reg + 1'b1;
                if (off_elapsed_reg != '1)
                    off_elapsed_next = off_elapsed_reg + 1'b1;
            end
            OP_SAMPLE:
            begin
                if (relay_reg)
                begin
                    if (max_hit)
                    begin
                        relay_next       = 1'b0;
                        off_elapsed_next = '0;
                        ev               = EV_OFF_TIME;
                    end
                    else if (!temp_below)
                    begin
                        relay_next       = 1'b0;
                        off_elapsed_next = '0;
                        ev               = EV_OFF_TEMP;
                    end
                end
                else if (temp_below && (err2 > band_s) && waited)
                begin
                    relay_next      = 1'b1;
                    first_run_next  = 1'b0;
                    on_elapsed_next = '0;
                    ev              = EV_ON;
                end
            end
            default: ;
        endcase
    end

    assign heater_on = relay_next;
    assign event_res = ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg       <= 1'b0;
            first_run_reg   <= 1'b1;
            on_elapsed_reg  <= '0;
            off_elapsed_reg <= '0;
        end
        else if (fire)
        begin
            relay_reg       <= relay_next;
            first_run_reg   <= first_run_next;
            on_elapsed_reg  <= on_elapsed_next;
            off_elapsed_reg <= off_elapsed_next;
        end
    end

endmodule

[rtl/heating_relay_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heating_relay_controller
// Bang-bang furnace relay with hysteresis, max on time and min off time.
//
//   channel   dir  transfer when          payload
//   s_axis    in   tvalid & tready        tuser: op, tdata: temperature
//   m_axis    out  tvalid & tready        tdata: heater_on, event_res
//   apb       in   psel&penable&pwrite    four registers at 0x0..0xC
//
// One item per cycle unless the output stalls; each item passes the input
// register, then the result register; state updates as it moves between them.
// Reset clears the relay, timers and sets the first-run flag; no clearing pass.
// A stalled output holds its result while the input register takes one more
// item; the input stalls only when both are full.
// ----------------------------------------------------------------------------
module heating_relay_controller
    import hrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [11:0] temperature
    input  logic              s_axis_tuser,   // [0] op
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] heater_on, [2:1] event_res
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t              cfg;
    logic              in_valid_reg;
    op_t               in_op_reg;
    logic [TEMP_W-1:0] in_temp_reg;
    logic              out_valid_reg;
    logic              out_heater_reg;
    event_t            out_event_reg;
    logic              advance;
    logic              fire;
    logic              heater_on;
    event_t            event_res;

    hrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hrc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fire        (fire),
        .op          (in_op_reg),
        .temperature (in_temp_reg),
        .heater_on   (heater_on),
        .event_res   (event_res)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg   <= op_t'(s_axis_tuser);
            in_temp_reg <= s_axis_tdata[TEMP_W-1:0];
        end
        if (fire)
        begin
            out_heater_reg <= heater_on;
            out_event_reg  <= event_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_event_reg, out_heater_reg};

endmodule
